@@ hdl/rpa_pkg.sv @@
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types, codes and pool tables for the register pool allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_W     = $clog2(REG_COUNT);
    localparam int PTR_W     = 4;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

    localparam logic [1:0] CLS_INT_TEMP  = 2'd0;
    localparam logic [1:0] CLS_INT_SAVED = 2'd1;
    localparam logic [1:0] CLS_FLT_TEMP  = 2'd2;
    localparam logic [1:0] CLS_FLT_SAVED = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EVICT     = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    localparam int IS_SIZE = 10;
    localparam int FS_SIZE = 12;

    localparam logic [REG_W-1:0] IS_LIST [IS_SIZE] = '{
        5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27
    };
    localparam logic [REG_W-1:0] FS_LIST [FS_SIZE] = '{
        5'd8, 5'd9, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25,
        5'd26, 5'd27
    };

    // pool membership masks; every list is in ascending order
    localparam logic [REG_COUNT-1:0] IT_MASK = 32'hF000_00E0;
    localparam logic [REG_COUNT-1:0] IS_MASK = 32'h0FFC_0000;
    localparam logic [REG_COUNT-1:0] FT_MASK = 32'hF000_00FF;
    localparam logic [REG_COUNT-1:0] FS_MASK = 32'h0FFC_0300;

    typedef struct packed {
        logic [1:0]       func;
        logic [1:0]       reg_class;
        logic [REG_W-1:0] reg_num;
    } rpa_req_t;

    typedef struct packed {
        logic [REG_W-1:0] granted_reg;
        logic [1:0]       status;
    } rpa_res_t;

    function automatic logic [REG_COUNT-1:0] pool_mask(input logic [1:0] cls);
        logic [REG_COUNT-1:0] m;
        case (cls)
            CLS_INT_TEMP:  m = IT_MASK;
            CLS_INT_SAVED: m = IS_MASK;
            CLS_FLT_TEMP:  m = FT_MASK;
            default:       m = FS_MASK;
        endcase
        return m;
    endfunction

endpackage

@@ hdl/rpa_core.sv @@
// ----------------------------------------------------------------------------
// rpa_core
// Used-bit files, victim pointers and the single-pass allocate/free/release logic.
// ----------------------------------------------------------------------------
module rpa_core
    import rpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  rpa_req_t req,
    output rpa_res_t res
);

    logic [REG_COUNT-1:0] int_used_reg, int_used_next;
    logic [REG_COUNT-1:0] flt_used_reg, flt_used_next;
    logic [PTR_W-1:0]     int_ptr_reg, int_ptr_next;
    logic [PTR_W-1:0]     flt_ptr_reg, flt_ptr_next;

    logic                 is_float;
    logic                 is_saved;
    logic [REG_COUNT-1:0] mask;
    logic [REG_COUNT-1:0] used_sel;
    logic [REG_COUNT-1:0] avail;
    logic                 found;
    logic [REG_W-1:0]     first_free;
    logic [PTR_W-1:0]     int_eff;
    logic [PTR_W-1:0]     flt_eff;
    logic [REG_W-1:0]     victim;

    always_comb
    begin
        is_float = (req.reg_class == CLS_FLT_TEMP) || (req.reg_class == CLS_FLT_SAVED);
        is_saved = (req.reg_class == CLS_INT_SAVED) || (req.reg_class == CLS_FLT_SAVED);
        mask     = pool_mask(req.reg_class);
        used_sel = is_float ? flt_used_reg : int_used_reg;
        avail    = mask & ~used_sel;
        found    = |avail;

        first_free = '0;
        for (int i = REG_COUNT - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                first_free = REG_W'(i);
            end
        end

        int_eff = (int_ptr_reg >= PTR_W'(IS_SIZE)) ? '0 : int_ptr_reg;
        flt_eff = (flt_ptr_reg >= PTR_W'(FS_SIZE)) ? '0 : flt_ptr_reg;
        victim  = is_float ? FS_LIST[flt_eff] : IS_LIST[int_eff];
    end

    always_comb
    begin
        int_used_next   = int_used_reg;
        flt_used_next   = flt_used_reg;
        int_ptr_next    = int_ptr_reg;
        flt_ptr_next    = flt_ptr_reg;
        res.granted_reg = '0;
        res.status      = ST_DONE;
        case (req.func)
            FUNC_ALLOC:
            begin
                if (found)
                begin
                    res.granted_reg = first_free;
                end
                else if (is_saved)
                begin
                    res.granted_reg = victim;
                    res.status      = ST_EVICT;
                    if (is_float)
                    begin
                        flt_ptr_next = flt_eff + PTR_W'(1);
                    end
                    else
                    begin
                        int_ptr_next = int_eff + PTR_W'(1);
                    end
                end
                else
                begin
                    res.status = ST_EXHAUSTED;
                end
                if (found || is_saved)
                begin
                    if (is_float)
                    begin
                        flt_used_next[res.granted_reg] = 1'b1;
                    end
                    else
                    begin
                        int_used_next[res.granted_reg] = 1'b1;
                    end
                end
            end
            FUNC_FREE:
            begin
                if (mask[req.reg_num])
                begin
                    if (is_float)
                    begin
                        flt_used_next[req.reg_num] = 1'b0;
                    end
                    else
                    begin
                        int_used_next[req.reg_num] = 1'b0;
                    end
                end
                else
                begin
                    res.status = ST_IGNORED;
                end
            end
            FUNC_RELEASE:
            begin
                int_used_next = int_used_reg & ~IS_MASK;
                flt_used_next = flt_used_reg & ~FS_MASK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_used_reg <= '0;
            flt_used_reg <= '0;
            int_ptr_reg  <= '0;
            flt_ptr_reg  <= '0;
        end
        else if (fire)
        begin
            int_used_reg <= int_used_next;
            flt_used_reg <= flt_used_next;
            int_ptr_reg  <= int_ptr_next;
            flt_ptr_reg  <= flt_ptr_next;
        end
    end

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(int_used_reg) && $stable(flt_used_reg)
                  && $stable(int_ptr_reg) && $stable(flt_ptr_reg))
        else $error("state changed without an item");

    a_exhaust_temp_only: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.status == ST_EXHAUSTED |->
            req.reg_class == CLS_INT_TEMP || req.reg_class == CLS_FLT_TEMP)
        else $error("saved pool reported exhaustion");

    a_grant_marked: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.func == FUNC_ALLOC && !is_float
            && (res.status == ST_DONE || res.status == ST_EVICT)
        |=> int_used_reg[$past(res.granted_reg)])
        else $error("granted integer register not marked used");

    a_int_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.status == ST_EVICT && !is_float |=>
            int_ptr_reg != '0 && int_ptr_reg <= PTR_W'(IS_SIZE))
        else $error("integer victim pointer out of range");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.func == FUNC_RELEASE |=>
            (int_used_reg & IS_MASK) == '0 && (flt_used_reg & FS_MASK) == '0)
        else $error("release left saved registers in use");

endmodule

@@ hdl/register_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// register_pool_allocator
// Four-pool register allocator with round-robin eviction for saved pools.
//
// Slave channel: one item per request (func, pool, register number).
// Master channel: one item per request (granted register, status).
// Each item is captured in an input register, processed in a single
// pass against the used-bit files and its result lands in an output
// register. Throughput is one item per cycle while the receiver keeps
// m_tready high, set by the single-pass allocate/free/release logic
// between the two registers.
// Items are processed strictly in order; each sees the state left by
// the one before it.
// Reset clears all used bits and both victim pointers; nothing is held.
// When the receiver stalls, the result stays in the output register and
// one further item may wait in the input register, after which s_tready
// drops until the result is taken.
// ----------------------------------------------------------------------------
module register_pool_allocator
    import rpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] reg_num
    input  logic [3:0] s_tuser,   // [1:0] func, [3:2] reg_class
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [4:0] granted_reg
    output logic [1:0] m_tuser    // [1:0] status
);

    logic     in_valid_reg;
    rpa_req_t in_req_reg;
    logic     out_valid_reg;
    rpa_res_t out_res_reg;
    rpa_res_t res;
    logic     adv;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    rpa_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (adv),
        .req   (in_req_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg.func      <= s_tuser[1:0];
            in_req_reg.reg_class <= s_tuser[3:2];
            in_req_reg.reg_num   <= s_tdata[REG_W-1:0];
        end
        if (adv)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - REG_W){1'b0}}, out_res_reg.granted_reg};
    assign m_tuser  = out_res_reg.status;

endmodule
